>>> rtl/anchor_box_decode_unit_defines.svh
// Assertion macros used by the checker file of the anchor box decoder.
`ifndef ANCHOR_BOX_DECODE_UNIT_DEFINES_SVH
`define ANCHOR_BOX_DECODE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ABD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("anchor box decode: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ABD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("anchor box decode: check failed");

`endif

>>> rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// Types and constants of the anchor box decoder: beat structs, fixed-point
// format, exponential approximation coefficients and divider sizes.
// ----------------------------------------------------------------------------
package abd_pkg;

  // Fraction bits of the Q formats
  localparam int FRAC_BITS = 8;

  // log2(e) in Q16 and the 2^f polynomial coefficients
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] P_C1      = 16'd43024;
  localparam logic [14:0] P_C2      = 15'd22512;

  // Datapath widths
  localparam int XW   = 17;                 // exponent argument
  localparam int MW   = XW + 18;            // argument times log2(e)
  localparam int NW   = MW - FRAC_BITS - 16; // integer part of the exponent
  localparam int PW   = 17;                 // 2^f in Q16
  localparam int DENW = 34;                 // softmax denominator
  localparam int DIVQ = 17;                 // quotient bits

  // Score path handling
  typedef enum logic [1:0] {
    SC_CALC,
    SC_ZERO,
    SC_MAX
  } abd_sc_e;

  typedef struct packed {
    logic signed [15:0] bg_logit;
    logic signed [15:0] fg_logit;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic signed [15:0] off_w;
    logic signed [15:0] off_h;
    logic signed [15:0] anchor_cx;
    logic signed [15:0] anchor_cy;
    logic        [14:0] anchor_w;
    logic        [14:0] anchor_h;
  } abd_in_t;

  typedef struct packed {
    logic        [15:0] fg_score;
    logic signed [15:0] box_cx;
    logic signed [15:0] box_cy;
    logic        [14:0] box_w;
    logic        [14:0] box_h;
  } abd_out_t;

endpackage

>>> rtl/anchor_box_decode_unit.sv
// Throughput: one anchor per cycle unless the output stalls; the 17-stage
// restoring divider of the softmax score sets the depth, each stage retiring
// one quotient bit. A stalled output beat freezes the whole pipeline in place.
// Reset clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// anchor_box_decode_unit
// Region proposal anchor decoder: two-class softmax foreground score and
// box decode (centre = offset * size + centre, size = exp(offset) * size).
// ----------------------------------------------------------------------------
module anchor_box_decode_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  abd_pkg::abd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output abd_pkg::abd_out_t out_data_o
);
  import abd_pkg::*;

  localparam int NSTG = 9 + DIVQ + 1;
  localparam int CPW  = 31;
  localparam int CSW  = CPW + 1;
  localparam int RW   = NW + 1;
  localparam logic signed [CSW-1:0] CP_HALF = CSW'(2 ** (FRAC_BITS - 1));

  logic            adv;
  logic [NSTG-1:0] vld_q;

  // Global advance: everything moves unless the output beat is held
  assign adv         = !(vld_q[NSTG-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Stage registers
  abd_in_t                   in_q;
  logic signed [XW-1:0]      x_d [3];
  logic signed [XW-1:0]      x_q [3];
  logic signed [CPW-1:0]     cp_d [2];
  logic signed [CPW-1:0]     cp_q [2];
  logic signed [15:0]        ctr_q [2];
  logic        [14:0]        sz_q [1:5][2];
  logic signed [MW-1:0]      m_d [3];
  logic signed [MW-1:0]      m_q [3];
  logic signed [15:0]        cen_d [2];
  logic signed [15:0]        cen_q [2:7][2];
  logic signed [NW-1:0]      n_d [3];
  logic signed [NW-1:0]      n_q [3:6][3];
  logic        [15:0]        f_d [3];
  logic        [15:0]        f_q [3];
  logic        [14:0]        t_d [3];
  logic        [14:0]        t_q [3];
  logic        [32:0]        pm_d [3];
  logic        [32:0]        pm_q [3];
  logic        [PW-1:0]      p_d [3];
  logic        [PW-1:0]      p_q [3];
  logic        [32:0]        pw_d;
  logic        [32:0]        pw_q;
  abd_sc_e                   sc6_d;
  abd_sc_e                   sc6_q;
  abd_sc_e                   sc7_q;
  logic        [31:0]        q_d [2];
  logic        [31:0]        q_q [2];
  logic                      zr_d [2];
  logic                      zr_q [2];
  logic        [DENW-1:0]    den_d;
  logic        [DENW-1:0]    den7_q;
  logic        [14:0]        bsz_d [2];
  logic        [14:0]        bsz_q [2];

  // Divider stages, index 0 is the initial remainder
  logic        [DENW-1:0]    rem_d [0:DIVQ];
  logic        [DENW-1:0]    rem_q [0:DIVQ];
  logic        [DENW-1:0]    dv_q  [0:DIVQ];
  logic        [DIVQ-1:0]    nlo_d [0:DIVQ];
  logic        [DIVQ-1:0]    nlo_q [0:DIVQ];
  logic        [DIVQ-1:0]    quo_d [0:DIVQ];
  logic        [DIVQ-1:0]    quo_q [0:DIVQ];
  abd_sc_e                   sc_q  [0:DIVQ];
  logic signed [15:0]        bcx_q [0:DIVQ];
  logic signed [15:0]        bcy_q [0:DIVQ];
  logic        [14:0]        bw_q  [0:DIVQ];
  logic        [14:0]        bh_q  [0:DIVQ];
  abd_out_t                  out_d;
  abd_out_t                  out_q;

  // Stage 1: exponent arguments and centre products
  always_comb begin
    x_d[0]  = XW'(in_q.bg_logit) - XW'(in_q.fg_logit);
    x_d[1]  = XW'(in_q.off_w);
    x_d[2]  = XW'(in_q.off_h);
    cp_d[0] = CPW'(in_q.off_x) * $signed(CPW'({1'b0, in_q.anchor_w}));
    cp_d[1] = CPW'(in_q.off_y) * $signed(CPW'({1'b0, in_q.anchor_h}));
  end

  // Stage 2: scale by log2(e); round, offset and clamp the centres
  always_comb begin
    logic signed [CSW-1:0] rnd;
    logic signed [CSW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      m_d[i] = MW'(x_q[i]) * MW'($signed({1'b0, LOG2E_Q16}));
    end
    for (int i = 0; i < 2; i++) begin
      rnd = CSW'(cp_q[i]) + CP_HALF;
      sum = (rnd >>> FRAC_BITS) + CSW'(ctr_q[i]);
      if (sum > CSW'(32767)) begin
        cen_d[i] = 16'sh7fff;
      end else if (sum < CSW'(-32768)) begin
        cen_d[i] = -16'sh8000;
      end else begin
        cen_d[i] = sum[15:0];
      end
    end
  end

  // Stage 3: split into integer and fraction, first polynomial product
  always_comb begin
    logic [30:0] tp;
    for (int i = 0; i < 3; i++) begin
      n_d[i] = m_q[i][MW-1:FRAC_BITS+16];
      f_d[i] = m_q[i][FRAC_BITS+15:FRAC_BITS];
      tp     = 31'(P_C2) * 31'(f_d[i]);
      t_d[i] = tp[30:16];
    end
  end

  // Stage 4: second polynomial product
  always_comb begin
    logic [16:0] g;
    for (int i = 0; i < 3; i++) begin
      g       = 17'(P_C1) + 17'(t_q[i]);
      pm_d[i] = 33'(f_q[i]) * 33'(g);
    end
  end

  // Stage 5: 2^f in Q16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_d[i] = 17'h10000 + pm_q[i][32:16];
    end
  end

  // Stage 6: score power of two, size products
  always_comb begin
    logic signed [NW-1:0] ns;
    logic        [5:0]    ra;
    ns   = n_q[5][0];
    ra   = 6'(-ns);
    pw_d = '0;
    if (ns >= NW'(17)) begin
      sc6_d = SC_ZERO;
    end else if (ns < NW'(-32)) begin
      sc6_d = SC_MAX;
    end else begin
      sc6_d = SC_CALC;
      if (ns >= NW'(0)) begin
        pw_d = 33'(p_q[0]) << ns[4:0];
      end else begin
        pw_d = 33'(p_q[0]) >> ra;
      end
    end
    for (int i = 0; i < 2; i++) begin
      q_d[i]  = 32'(sz_q[5][i]) * 32'(p_q[i+1]);
      zr_d[i] = (sz_q[5][i] == 15'd0);
    end
  end

  // Stage 7: denominator; size shift with round half up and clamp
  always_comb begin
    logic signed [RW-1:0] rr;
    logic        [5:0]    sh;
    logic        [32:0]   v;
    den_d = DENW'(65536) + DENW'(pw_q);
    for (int i = 0; i < 2; i++) begin
      rr = RW'(16) - RW'(n_q[6][i+1]);
      sh = rr[5:0];
      v  = (33'(q_q[i]) + (33'd1 << (sh - 6'd1))) >> sh;
      if (zr_q[i]) begin
        bsz_d[i] = '0;
      end else if (rr <= RW'(0)) begin
        bsz_d[i] = 15'h7fff;
      end else if (rr >= RW'(40)) begin
        bsz_d[i] = '0;
      end else if (v > 33'd32767) begin
        bsz_d[i] = 15'h7fff;
      end else begin
        bsz_d[i] = v[14:0];
      end
    end
  end

  // Stage 8: dividend 2^32 + den/2, upper bits seed the remainder
  // Stages 9..25: one restoring quotient bit each
  always_comb begin
    logic [DENW-1:0] num;
    logic [DENW:0]   tt;
    num      = DENW'(64'h1_0000_0000) + (den7_q >> 1);
    rem_d[0] = DENW'(num[DENW-1:DIVQ]);
    nlo_d[0] = num[DIVQ-1:0];
    quo_d[0] = '0;
    for (int k = 1; k <= DIVQ; k++) begin
      tt       = {rem_q[k-1], nlo_q[k-1][DIVQ-1]};
      nlo_d[k] = nlo_q[k-1] << 1;
      if (tt >= {1'b0, dv_q[k-1]}) begin
        rem_d[k] = DENW'(tt - {1'b0, dv_q[k-1]});
        quo_d[k] = {quo_q[k-1][DIVQ-2:0], 1'b1};
      end else begin
        rem_d[k] = tt[DENW-1:0];
        quo_d[k] = {quo_q[k-1][DIVQ-2:0], 1'b0};
      end
    end
  end

  // Output beat: clamp the score
  always_comb begin
    out_d.box_cx = bcx_q[DIVQ];
    out_d.box_cy = bcy_q[DIVQ];
    out_d.box_w  = bw_q[DIVQ];
    out_d.box_h  = bh_q[DIVQ];
    case (sc_q[DIVQ])
      SC_ZERO: out_d.fg_score = '0;
      SC_MAX:  out_d.fg_score = 16'hffff;
      default: out_d.fg_score = quo_q[DIVQ][DIVQ-1] ? 16'hffff : quo_q[DIVQ][15:0];
    endcase
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
      for (int i = 0; i < 3; i++) begin
        x_q[i]    <= x_d[i];
        m_q[i]    <= m_d[i];
        n_q[3][i] <= n_d[i];
        f_q[i]    <= f_d[i];
        t_q[i]    <= t_d[i];
        n_q[4][i] <= n_q[3][i];
        pm_q[i]   <= pm_d[i];
        n_q[5][i] <= n_q[4][i];
        p_q[i]    <= p_d[i];
        n_q[6][i] <= n_q[5][i];
      end
      cp_q[0]     <= cp_d[0];
      cp_q[1]     <= cp_d[1];
      ctr_q[0]    <= in_q.anchor_cx;
      ctr_q[1]    <= in_q.anchor_cy;
      sz_q[1][0]  <= in_q.anchor_w;
      sz_q[1][1]  <= in_q.anchor_h;
      for (int s = 2; s <= 5; s++) begin
        sz_q[s] <= sz_q[s-1];
      end
      cen_q[2]    <= cen_d;
      for (int s = 3; s <= 7; s++) begin
        cen_q[s] <= cen_q[s-1];
      end
      pw_q        <= pw_d;
      sc6_q       <= sc6_d;
      q_q         <= q_d;
      zr_q        <= zr_d;
      den7_q      <= den_d;
      sc7_q       <= sc6_q;
      bsz_q       <= bsz_d;
      // divider seed and box delay line
      rem_q[0]    <= rem_d[0];
      nlo_q[0]    <= nlo_d[0];
      quo_q[0]    <= quo_d[0];
      dv_q[0]     <= den7_q;
      sc_q[0]     <= sc7_q;
      bcx_q[0]    <= cen_q[7][0];
      bcy_q[0]    <= cen_q[7][1];
      bw_q[0]     <= bsz_q[0];
      bh_q[0]     <= bsz_q[1];
      for (int k = 1; k <= DIVQ; k++) begin
        rem_q[k] <= rem_d[k];
        nlo_q[k] <= nlo_d[k];
        quo_q[k] <= quo_d[k];
        dv_q[k]  <= dv_q[k-1];
        sc_q[k]  <= sc_q[k-1];
        bcx_q[k] <= bcx_q[k-1];
        bcy_q[k] <= bcy_q[k-1];
        bw_q[k]  <= bw_q[k-1];
        bh_q[k]  <= bh_q[k-1];
      end
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/abd_check.sv
// ----------------------------------------------------------------------------
// abd_check
// Port-level checks of the anchor box decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "anchor_box_decode_unit_defines.svh"

module abd_check (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input abd_pkg::abd_out_t out_data_o
);
  import abd_pkg::*;

  // Input side only backs up when a result beat is held
  `ABD_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // An empty output register never blocks the input
  `ABD_ASSERT_NOW(a_empty_free, !out_valid_o, !in_stall_o)
  // A held result beat stays and keeps its payload
  `ABD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

bind anchor_box_decode_unit abd_check u_abd_check (.*);

>>> verif/anchor_box_decode_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anchor_box_decode_unit_tb
// Self-checking bench for the anchor decoder: directed anchors, some at the
// field extremes, then random anchors, each result compared field by field
// against a typed-in result or a bit-accurate score and box predictor.
// ----------------------------------------------------------------------------
module anchor_box_decode_unit_tb;
  import abd_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int DRAIN_CYCLES = 40;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  abd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  abd_out_t out_data_o;

  abd_out_t decoded_q[$];
  int       n_errors;
  bit       send_done;

  anchor_box_decode_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor division by 2^s for signed values
  function automatic longint floor_sh(longint a, int s);
    floor_sh = a >>> s;
  endfunction

  // Split x * log2(e) into integer exponent and 2^frac in Q16
  function automatic void pow2_split(longint x, output longint n, output longint p);
    longint u, f;
    u = floor_sh(x * 94548, FRAC_BITS);
    n = floor_sh(u, 16);
    f = u - n * 65536;
    p = 65536 + ((f * (43024 + ((22512 * f) >>> 16))) >>> 16);
  endfunction

  function automatic logic [15:0] softmax_fg(longint bg, longint fg);
    longint n, p, pw, den, q;
    pow2_split(bg - fg, n, p);
    if (n >= 32) return 16'd0;
    if (n < -32) return 16'hFFFF;
    pw = (n >= 0) ? (p << n) : (p >> (-n));
    den = 65536 + pw;
    q = ((64'sd1 << 32) + den / 2) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] box_centre(longint off, longint sz, longint ctr);
    longint v;
    v = floor_sh(off * sz + (64'sd1 << (FRAC_BITS - 1)), FRAC_BITS) + ctr;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [14:0] box_size(longint off, longint sz);
    longint n, p, q, s;
    logic [63:0] v;
    if (sz == 0) return 15'd0;
    pow2_split(off, n, p);
    q = sz * p;
    s = n - 16;
    if (s >= 0) begin
      if (s > 31) return 15'h7FFF;
      v = 64'(q) << s;
    end else begin
      if (-s >= 40) return 15'd0;
      v = (64'(q) + (64'd1 << (-s - 1))) >> (-s);
    end
    return (v > 32767) ? 15'h7FFF : v[14:0];
  endfunction

  function automatic abd_out_t decode_anchor(abd_in_t a);
    abd_out_t r;
    r.fg_score = softmax_fg(a.bg_logit, a.fg_logit);
    r.box_cx   = box_centre(a.off_x, {1'b0, a.anchor_w}, a.anchor_cx);
    r.box_cy   = box_centre(a.off_y, {1'b0, a.anchor_h}, a.anchor_cy);
    r.box_w    = box_size(a.off_w, a.anchor_w);
    r.box_h    = box_size(a.off_h, a.anchor_h);
    return r;
  endfunction

  // Directed rows; known results are typed in where obvious
  typedef struct {
    abd_in_t  beat;
    bit       known;
    abd_out_t result;
  } anchor_row_t;

  anchor_row_t dir_rows[$];

  // Queue helpers
  function automatic void add_row(anchor_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void expect_beat(abd_out_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  function automatic abd_in_t mk(int bg, int fg, int ox, int oy, int ow, int oh,
                                 int cx, int cy, int aw, int ah);
    abd_in_t a;
    a = '{16'(bg), 16'(fg), 16'(ox), 16'(oy), 16'(ow), 16'(oh), 16'(cx),
          16'(cy), 15'(aw), 15'(ah)};
    return a;
  endfunction

  function automatic abd_in_t rand_anchor();
    abd_in_t      a;
    logic [159:0] rb;
    rb = {$urandom, $urandom, $urandom, $urandom, $urandom};
    a  = rb[$bits(abd_in_t)-1:0];
    case ($urandom_range(0, 3))
      0: begin
        // typical network output: small logits and offsets
        a.bg_logit = 16'($signed($urandom_range(0, 4096)) - 2048);
        a.fg_logit = 16'($signed($urandom_range(0, 4096)) - 2048);
        a.off_w    = 16'($signed($urandom_range(0, 2048)) - 1024);
        a.off_h    = 16'($signed($urandom_range(0, 2048)) - 1024);
        a.off_x    = 16'($signed($urandom_range(0, 1024)) - 512);
        a.off_y    = 16'($signed($urandom_range(0, 1024)) - 512);
      end
      1: begin
        a.off_w = 16'($signed($urandom_range(0, 8192)) - 4096);
        a.off_h = 16'($signed($urandom_range(0, 8192)) - 4096);
      end
      default: ;
    endcase
    return a;
  endfunction

  // Drive one beat from a falling edge; returns on the falling edge after
  // it was taken, with valid still high for a back-to-back follower
  task automatic send_anchor(abd_in_t a);
    int idle;
    idle = $urandom_range(0, 9);
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    anchor_row_t row;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    send_done  = 1'b0;
    n_errors   = 0;
    rst_ni     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero anchor: equal logits give one half, zero size gives zero
    row = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{16'h8000, 0, 0, 0, 0}};
    add_row(row);
    // huge logit gaps saturate the score both ways
    row = '{mk(32767, -32768, 0, 0, 0, 0, 5, -5, 0, 0), 1'b1, '{16'd0, 5, -5, 0, 0}};
    add_row(row);
    row = '{mk(-32768, 32767, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{16'hFFFF, 0, 0, 0, 0}};
    add_row(row);
    // centre saturation high and low, size saturation and underflow
    row = '{mk(0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767),
            1'b1, '{16'h8000, 16'sh7FFF, -16'sd32768, 15'h7FFF, 15'd0}};
    add_row(row);
    row = '{mk(0, 0, -32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767),
            1'b1, '{16'h8000, -16'sd32768, 16'sh7FFF, 15'd0, 15'h7FFF}};
    add_row(row);
    // anchor of 256 by 512, zero offsets: size passes through
    row = '{mk(256, 0, 0, 0, 0, 0, 1000, -1000, 256, 512), 1'b0, '0};
    add_row(row);
    row = '{mk(-1, 1, 128, -128, 256, -256, 100, 100, 1, 32767), 1'b0, '0};
    add_row(row);
    row = '{mk(2048, -2048, 1, -1, 1, -1, 0, 0, 32767, 1), 1'b0, '0};
    add_row(row);
    row = '{mk(8000, 0, -129, 127, 1500, -1500, -7, 7, 300, 300), 1'b0, '0};
    add_row(row);
    row = '{mk(-8000, 0, 5, 5, 3000, -3000, 0, 0, 16384, 16384), 1'b0, '0};
    add_row(row);

    foreach (dir_rows[i]) begin
      expect_beat(dir_rows[i].known ? dir_rows[i].result
                                    : decode_anchor(dir_rows[i].beat));
      send_anchor(dir_rows[i].beat);
    end

    // Random anchors
    repeat (N_RANDOM) begin
      abd_in_t a;
      a = rand_anchor();
      expect_beat(decode_anchor(a));
      send_anchor(a);
    end
    in_valid_i <= 1'b0;
    send_done = 1'b1;
  end

  // Receiver stall: per beat a random wait, with runs of no stall
  initial begin
    int w;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      out_stall_i <= (w != 0);
      if (w != 0) begin
        repeat (w - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Result check
  always @(posedge clk_i) begin
    abd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data_o.fg_score !== want.fg_score) begin
          $error("fg_score exp %0d got %0d", want.fg_score, out_data_o.fg_score);
          n_errors++;
        end
        if (out_data_o.box_cx !== want.box_cx) begin
          $error("box_cx exp %0d got %0d", want.box_cx, out_data_o.box_cx);
          n_errors++;
        end
        if (out_data_o.box_cy !== want.box_cy) begin
          $error("box_cy exp %0d got %0d", want.box_cy, out_data_o.box_cy);
          n_errors++;
        end
        if (out_data_o.box_w !== want.box_w) begin
          $error("box_w exp %0d got %0d", want.box_w, out_data_o.box_w);
          n_errors++;
        end
        if (out_data_o.box_h !== want.box_h) begin
          $error("box_h exp %0d got %0d", want.box_h, out_data_o.box_h);
          n_errors++;
        end
      end
    end
  end

  // End of run
  initial begin
    @(posedge send_done);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("anchor_box_decode_unit_tb OK");
    end else begin
      $display("anchor_box_decode_unit_tb NOT OK");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("anchor_box_decode_unit_tb NOT OK");
    $finish;
  end

endmodule
